// ----- src/adsr_pkg.sv -----
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared types and constants of the linear ADSR envelope generator.
// ----------------------------------------------------------------------------
`default_nettype none

package adsr_pkg;

   localparam int LEN_W   = 16;    // attack, decay and release lengths
   localparam int VEL_W   = 17;    // velocity, sustain and output, 65536 = 1.0
   localparam int POS_W   = 18;    // sample position counter
   localparam int REQ_W   = 2;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   localparam logic [VEL_W-1:0] UNIT16  = 17'h10000;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   // request codes
   localparam logic [REQ_W-1:0] REQ_TICK     = 2'd0;
   localparam logic [REQ_W-1:0] REQ_NOTE_ON  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_NOTE_OFF = 2'd2;

   // register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_ATTACK  = 2'd0;
   localparam logic [1:0] REG_DECAY   = 2'd1;
   localparam logic [1:0] REG_SUSTAIN = 2'd2;
   localparam logic [1:0] REG_RELEASE = 2'd3;

   localparam logic [LEN_W-1:0] ATTACK_RESET  = 16'd4800;
   localparam logic [LEN_W-1:0] DECAY_RESET   = 16'd4800;
   localparam logic [VEL_W-1:0] SUSTAIN_RESET = 17'd45875;
   localparam logic [LEN_W-1:0] RELEASE_RESET = 16'd9600;

   typedef enum logic [4:0] {
      ENV_IDLE    = 5'b00001,
      ENV_ATTACK  = 5'b00010,
      ENV_DECAY   = 5'b00100,
      ENV_SUSTAIN = 5'b01000,
      ENV_RELEASE = 5'b10000
   } phase_type;

endpackage

`default_nettype wire

// ----- src/adsr_if.sv -----
// ----------------------------------------------------------------------------
// adsr_req_if / adsr_rsp_if
// Valid/ready channels for envelope requests and envelope level results.
// ----------------------------------------------------------------------------
`default_nettype none

interface adsr_req_if import adsr_pkg::*;;
   logic             valid;
   logic             ready;
   logic [REQ_W-1:0] req_type;
   logic [VEL_W-1:0] note_velocity;

   modport source (output valid, output req_type, output note_velocity, input ready);
   modport sink   (input valid, input req_type, input note_velocity, output ready);
endinterface

interface adsr_rsp_if import adsr_pkg::*;;
   logic             valid;
   logic             ready;
   logic [VEL_W-1:0] level_out;

   modport source (output valid, output level_out, input ready);
   modport sink   (input valid, input level_out, output ready);
endinterface

`default_nettype wire

// ----- src/adsr_div.sv -----
// ----------------------------------------------------------------------------
// adsr_div
// Restoring divider, one quotient bit per cycle, for the per-sample step.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_div import adsr_pkg::*; #(
   parameter int NUM_W = 24
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] dividend,
   input  wire logic [LEN_W-1:0] divisor,
   output logic                  done,
   output logic [NUM_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] qd_ff, qd_in;
   logic [LEN_W-1:0] dsr_ff, dsr_in;
   logic [LEN_W:0]   shifted;
   logic             ge;

   // dividend bits leave at the top while quotient bits enter at the bottom
   assign shifted = {rem_ff, qd_ff[NUM_W-1]};
   assign ge      = shifted >= {1'b0, dsr_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      qd_in   = qd_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         cnt_in = CNT_W'(NUM_W);
         rem_in = '0;
         qd_in  = dividend;
         dsr_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
         // remainder stays below the divisor, so it fits in LEN_W bits
         rem_in  = ge ? LEN_W'(shifted - {1'b0, dsr_ff}) : shifted[LEN_W-1:0];
         qd_in   = {qd_ff[NUM_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      qd_ff  <= qd_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = qd_ff;

endmodule

`default_nettype wire

// ----- src/adsr_mul.sv -----
// ----------------------------------------------------------------------------
// adsr_mul
// Shift-add multiplier, one velocity bit per cycle, level times velocity.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_mul import adsr_pkg::*; #(
   parameter int MCAND_W = 24
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [MCAND_W-1:0]       mcand,
   input  wire logic [VEL_W-1:0]         mplier,
   output logic                          done,
   output logic [MCAND_W+VEL_W-1:0]      product
);

   localparam int P_W   = MCAND_W + VEL_W;
   localparam int CNT_W = $clog2(VEL_W + 1);

   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic [MCAND_W-1:0] mcand_ff, mcand_in;
   logic [P_W-1:0]     p_ff, p_in;
   logic [MCAND_W:0]   sum;

   // multiplier bits sit in the low part and are consumed lsb first
   assign sum = {1'b0, p_ff[P_W-1:VEL_W]} + (p_ff[0] ? {1'b0, mcand_ff} : '0);

   always_comb begin
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      mcand_in = mcand_ff;
      p_in     = p_ff;
      if (start) begin
         cnt_in   = CNT_W'(VEL_W);
         mcand_in = mcand;
         p_in     = {{MCAND_W{1'b0}}, mplier};
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
         p_in    = {sum, p_ff[VEL_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      mcand_ff <= mcand_in;
      p_ff     <= p_in;
   end

   assign done    = done_ff;
   assign product = p_ff;

endmodule

`default_nettype wire

// ----- src/adsr_envelope_generator.sv -----
// ----------------------------------------------------------------------------
// adsr_envelope_generator
// Linear ADSR envelope with a bit-serial step divider and output multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one word per request: a sample tick, a note on (with
//   velocity) or a note off. Only a tick returns a word on rsp_ch, holding
//   the envelope level times the velocity, 65536 = 1.0. The user is to write
//   the four length/sustain registers over the APB port only while the block
//   is idle; the block does not enforce this. Reads return the stored values.
// Sequence:
//   note on / note off: taken with no result.
//   tick in attack, decay or release: the step goes through the divider and
//   then through the multiplier before the result.
//   tick in idle or sustain: the divider is skipped.
//   One request is worked on at a time; req_ch.ready is high only when the
//   sequencer is free, so a tick is taken only once the last one is through.
// Stall: a finished result waits in the output register while the next
//   request is taken; a second result waits until rsp_ch takes the first.
// Reset: level 0, velocity 1.0, phase idle, registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_envelope_generator import adsr_pkg::*; #(
   parameter int LEVEL_FRAC_BITS = 23
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready,
   adsr_req_if.sink               req_ch,
   adsr_rsp_if.source             rsp_ch
);

   localparam int LW        = LEVEL_FRAC_BITS + 1;
   localparam int SUS_SHIFT = LEVEL_FRAC_BITS - 16;
   localparam logic [LW-1:0] LEVEL_ONE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_DIV  = 4'b0010,
      S_MUL  = 4'b0100,
      S_OUT  = 4'b1000
   } seq_state_type;

   // configuration registers
   logic [LEN_W-1:0] attack_ff, decay_ff, release_ff;
   logic [VEL_W-1:0] sustain_ff;
   logic             cfg_write;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff  <= ATTACK_RESET;
         decay_ff   <= DECAY_RESET;
         sustain_ff <= SUSTAIN_RESET;
         release_ff <= RELEASE_RESET;
      end else if (cfg_write) begin
         case (paddr[3:2])
            REG_ATTACK:  attack_ff  <= pwdata[LEN_W-1:0];
            REG_DECAY:   decay_ff   <= pwdata[LEN_W-1:0];
            REG_SUSTAIN: sustain_ff <= pwdata[VEL_W-1:0];
            REG_RELEASE: release_ff <= pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_ATTACK:  prdata = DATA_W'(attack_ff);
         REG_DECAY:   prdata = DATA_W'(decay_ff);
         REG_SUSTAIN: prdata = DATA_W'(sustain_ff);
         REG_RELEASE: prdata = DATA_W'(release_ff);
         default:     prdata = '0;
      endcase
   end

   // envelope state
   seq_state_type    state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [LW-1:0]    level_ff, level_in;
   logic [VEL_W-1:0] vel_ff, vel_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VEL_W-1:0] level_out_ff, level_out_in;

   logic                   div_start, div_done;
   logic [LW-1:0]          div_dividend, div_quotient;
   logic [LEN_W-1:0]       div_divisor;
   logic                   mul_start, mul_done;
   logic [LW+VEL_W-1:0]    mul_product;

   logic [VEL_W-1:0] sus16;
   logic [LW-1:0]    sus_level;
   logic [LEN_W-1:0] attack_nz, decay_nz, release_nz;
   logic [LW:0]      attack_sum;
   logic [LW-1:0]    level_down;
   logic [POS_W-1:0] pos_next;
   logic [LEN_W:0]   ad_total;
   logic             accept, out_free;

   assign sus16      = (sustain_ff > UNIT16) ? UNIT16 : sustain_ff;
   assign sus_level  = LW'(sus16) << SUS_SHIFT;
   assign attack_nz  = (attack_ff == '0)  ? LEN_W'(1) : attack_ff;
   assign decay_nz   = (decay_ff == '0)   ? LEN_W'(1) : decay_ff;
   assign release_nz = (release_ff == '0) ? LEN_W'(1) : release_ff;

   assign attack_sum = {1'b0, level_ff} + {1'b0, div_quotient};
   assign level_down = (level_ff > div_quotient) ? level_ff - div_quotient : '0;
   assign pos_next   = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
   assign ad_total   = {1'b0, attack_ff} + {1'b0, decay_ff};

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      level_in     = level_ff;
      vel_in       = vel_ff;
      pos_in       = pos_ff;
      div_start    = 1'b0;
      div_dividend = LEVEL_ONE;
      div_divisor  = attack_nz;
      mul_start    = 1'b0;
      rsp_valid_in = (rsp_valid_ff && rsp_ch.ready) ? 1'b0 : rsp_valid_ff;
      level_out_in = level_out_ff;

      // step operands follow the current phase
      case (phase_ff)
         ENV_DECAY: begin
            div_dividend = LEVEL_ONE - sus_level;
            div_divisor  = decay_nz;
         end
         ENV_RELEASE: begin
            div_dividend = sus_level;
            div_divisor  = release_nz;
         end
         default: ;
      endcase

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_ch.req_type)
                  REQ_NOTE_ON: begin
                     phase_in = ENV_ATTACK;
                     vel_in   = (req_ch.note_velocity > UNIT16) ? UNIT16
                                                                : req_ch.note_velocity;
                     pos_in   = '0;
                  end
                  REQ_NOTE_OFF: phase_in = ENV_RELEASE;
                  REQ_TICK: begin
                     case (phase_ff)
                        ENV_ATTACK, ENV_DECAY, ENV_RELEASE: begin
                           div_start = 1'b1;
                           state_in  = S_DIV;
                        end
                        ENV_SUSTAIN: begin
                           level_in  = sus_level;
                           pos_in    = pos_next;
                           mul_start = 1'b1;
                           state_in  = S_MUL;
                        end
                        default: begin
                           mul_start = 1'b1;
                           state_in  = S_MUL;
                        end
                     endcase
                  end
                  default: ;
               endcase
            end
         end
         S_DIV: begin
            if (div_done) begin
               case (phase_ff)
                  ENV_ATTACK: begin
                     level_in = (attack_sum > {1'b0, LEVEL_ONE}) ? LEVEL_ONE
                                                                 : attack_sum[LW-1:0];
                     if (pos_ff > POS_W'(attack_ff) || level_in == LEVEL_ONE) begin
                        phase_in = ENV_DECAY;
                     end
                  end
                  ENV_DECAY: begin
                     level_in = level_down;
                     if (level_down == '0) begin
                        phase_in = ENV_IDLE;
                     end else if (pos_ff > POS_W'(ad_total)) begin
                        phase_in = ENV_SUSTAIN;
                     end
                  end
                  default: begin
                     // release: a tick that finds the level at zero ends the note
                     if (level_ff == '0) begin
                        phase_in = ENV_IDLE;
                     end else begin
                        level_in = level_down;
                     end
                  end
               endcase
               pos_in    = pos_next;
               mul_start = 1'b1;
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            if (mul_done) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  level_out_in = mul_product[LEVEL_FRAC_BITS +: VEL_W];
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               level_out_in = mul_product[LEVEL_FRAC_BITS +: VEL_W];
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= ENV_IDLE;
         level_ff     <= '0;
         vel_ff       <= UNIT16;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         level_ff     <= level_in;
         vel_ff       <= vel_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      level_out_ff <= level_out_in;
   end

   assign req_ch.ready     = (state_ff == S_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.level_out = level_out_ff;

   adsr_div #(
      .NUM_W (LW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   adsr_mul #(
      .MCAND_W (LW)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (level_in),
      .mplier  (vel_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   // level stays within 0 .. 1.0
   assert property (@(posedge clock) disable iff (reset)
      level_ff <= LEVEL_ONE)
      else $error("envelope level above one");

   // divider finishes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider done outside divide state");

   // multiplier finishes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == S_MUL)
      else $error("multiplier done outside multiply state");

   // a new result word comes only from a finished product
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_MUL || $past(state_ff) == S_OUT))
      else $error("result word without a product");

endmodule

`default_nettype wire
